// ===== rtl/gdew_pkg.sv =====
// gdew_pkg: shared types, constants and the compare helper for the
// grayscale dilate/erode window block. No dependencies.
package gdew_pkg;

    localparam int PIX_W     = 15;   // pixel width
    localparam int POS_W     = 9;    // reported row/column width
    localparam int KSZ_W     = 3;    // kernel size register width
    localparam int CFG_IDX_W = 2;    // config register index width

    localparam logic [PIX_W-1:0] PIX_MAX = 15'h7FFF;  // erosion start value

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL = 2'd1;

    localparam logic             MODE_DILATE = 1'b0;
    localparam logic             MODE_ERODE  = 1'b1;
    localparam logic [KSZ_W-1:0] KSZ_RESET   = 3'd3;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } pix_t;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
    } res_t;

    // control from the top level to every cell of the chain
    typedef struct packed {
        logic             adv;      // stage-1 item moves on: write store, shift window
        logic             rd_en;    // new request accepted: read store
        logic             bypass;   // last write hit the column being processed
        logic             mode;
        logic [KSZ_W-1:0] ksize;    // effective kernel size, 1..MAX_KERNEL
    } cell_ctrl_t;

    // one step of the window reduction: max for dilation, min for erosion
    function automatic logic [PIX_W-1:0] pick(input logic mode,
                                              input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        if (mode == MODE_ERODE)
            return (b < a) ? b : a;
        else
            return (b > a) ? b : a;
    endfunction

endpackage

// ===== rtl/grayscale_dilate_erode_window_top.sv =====
// grayscale_dilate_erode_window_top: grayscale dilation/erosion over a square
// window on a raster pixel stream. Uses gdew_pkg, gdew_cell (and gdew_ram).
//
// Usage
//   pix channel  : one request per pixel in raster order; frame_start marks row 0,
//                  column 0 and restarts the counters. Counters also wrap at the
//                  end of a frame, so frame_start may be left low between frames.
//   res channel  : one request per window lying wholly inside the frame, carrying
//                  the window max (mode 0) or min (mode 1) and its centre row/col.
//                  Border pixels produce nothing.
//   cfg channel  : index 0 = mode, index 1 = kernel_size (0 acts as 1, above
//                  MAX_KERNEL acts as MAX_KERNEL). Always ready; write only while
//                  the pipeline is empty.
// Timing
//   Pipeline: an accepted pixel passes the store read, the window update + row
//   reduce, and the column reduce into the output reg, each registered.
//   Throughput: one pixel per clock while res is not stalled, limited by the
//   single write port of each line store RAM, which is written once per pixel.
// Reset / stall
//   Reset clears counters, pipeline valids and config (dilation, 3x3). Line
//   stores are not cleared; no clearing pass. While res is stalled the pipeline
//   keeps taking pixels until its two internal stages are full, and results
//   of border pixels drain without waiting.
module grayscale_dilate_erode_window_top #(
    parameter int IMAGE_WIDTH  = 512,
    parameter int IMAGE_HEIGHT = 512,
    parameter int MAX_KERNEL   = 7
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // pixel requests
    input  logic                               pix_valid,
    output logic                               pix_ready,
    input  gdew_pkg::pix_t                     pix,
    // result requests
    output logic                               res_valid,
    input  logic                               res_ready,
    output gdew_pkg::res_t                     res,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gdew_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gdew_pkg::KSZ_W-1:0]         cfg_data
);

    localparam int COL_W = $clog2(IMAGE_WIDTH);
    localparam int ROW_W = $clog2(IMAGE_HEIGHT);
    localparam int PW    = gdew_pkg::PIX_W;
    localparam int KW    = gdew_pkg::KSZ_W;

    // ---------------- configuration ----------------
    logic          mode_reg;
    logic [KW-1:0] ksize_reg;
    logic [KW-1:0] k_eff;
    logic [KW-1:0] k_m1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= gdew_pkg::MODE_DILATE;
            ksize_reg <= gdew_pkg::KSZ_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gdew_pkg::CFG_MODE:   mode_reg  <= cfg_data[0];
                gdew_pkg::CFG_KERNEL: ksize_reg <= cfg_data;
                default: ;  // unknown index ignored
            endcase
        end
    end

    always_comb
    begin
        if (ksize_reg == '0)
            k_eff = KW'(1);
        else if (int'(ksize_reg) > MAX_KERNEL)
            k_eff = KW'(MAX_KERNEL);
        else
            k_eff = ksize_reg;
    end

    assign k_m1 = k_eff - KW'(1);

    // ---------------- handshake / pipeline control ----------------
    logic pix_acc;
    logic s1_valid_reg, s2_valid_reg, s2_emit_reg, res_valid_reg;
    logic s1_adv, s2_free, s2_drain, res_free;

    assign res_free  = !res_valid_reg || res_ready;
    assign s2_drain  = s2_valid_reg && (!s2_emit_reg || res_free);
    assign s2_free   = !s2_valid_reg || s2_drain;
    assign s1_adv    = s1_valid_reg && s2_free;
    assign pix_ready = !s1_valid_reg || s1_adv;
    assign pix_acc   = pix_valid && pix_ready;

    // ---------------- raster counters ----------------
    logic [COL_W-1:0] col_reg, cur_col;
    logic [ROW_W-1:0] row_reg, cur_row;
    logic             col_last, row_last;

    assign cur_col  = pix.frame_start ? '0 : col_reg;
    assign cur_row  = pix.frame_start ? '0 : row_reg;
    assign col_last = (cur_col == COL_W'(IMAGE_WIDTH - 1));
    assign row_last = (cur_row == ROW_W'(IMAGE_HEIGHT - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (pix_acc)
        begin
            col_reg <= col_last ? '0 : cur_col + COL_W'(1);
            if (col_last)
            begin
                row_reg <= row_last ? '0 : cur_row + ROW_W'(1);
            end
            else
            begin
                row_reg <= cur_row;
            end
        end
    end

    // ---------------- stage 1: store read in flight ----------------
    logic [PW-1:0]    s1_pix_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             lw_valid_reg;      // a store write has happened
    logic [COL_W-1:0] lw_col_reg;        // column of the most recent store write

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            if (pix_acc)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
                lw_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_pix_reg <= pix.pixel;
            s1_col_reg <= cur_col;
            s1_row_reg <= cur_row;
        end
        if (s1_adv)
        begin
            lw_col_reg <= s1_col_reg;
        end
    end

    // ---------------- cell chain ----------------
    gdew_pkg::cell_ctrl_t ctrl;
    logic [PW-1:0] chain   [MAX_KERNEL+1];
    logic [PW-1:0] row_res [MAX_KERNEL];

    always_comb
    begin
        ctrl.adv    = s1_adv;
        ctrl.rd_en  = pix_acc;
        // read was issued no earlier than the last write: forward on a column hit
        ctrl.bypass = lw_valid_reg && (lw_col_reg == s1_col_reg);
        ctrl.mode   = mode_reg;
        ctrl.ksize  = k_eff;
    end

    assign chain[0] = s1_pix_reg;

    generate
        for (genvar j = 0; j < MAX_KERNEL; j++)
        begin : g_cell
            gdew_cell #(
                .IMAGE_WIDTH (IMAGE_WIDTH),
                .MAX_KERNEL  (MAX_KERNEL),
                .IDX         (j)
            ) u_cell (
                .clk     (clk),
                .ctrl    (ctrl),
                .wr_addr (s1_col_reg),
                .rd_addr (cur_col),
                .col_in  (chain[j]),
                .col_out (chain[j+1]),
                .row_res (row_res[j])
            );
        end
    endgenerate

    // ---------------- stage 2: row results held in the cells ----------------
    logic                          s1_emit;
    logic [gdew_pkg::POS_W-1:0]    s2_row_reg, s2_col_reg;
    logic [gdew_pkg::POS_W-1:0]    ctr_row, ctr_col;

    assign s1_emit = (s1_row_reg >= ROW_W'(k_m1)) && (s1_col_reg >= COL_W'(k_m1));
    // centre = top-left + k/2 = current - (k-1)/2
    assign ctr_row = gdew_pkg::POS_W'(s1_row_reg - ROW_W'(k_m1 >> 1));
    assign ctr_col = gdew_pkg::POS_W'(s1_col_reg - COL_W'(k_m1 >> 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s2_emit_reg  <= 1'b0;
        end
        else if (s1_adv)
        begin
            s2_valid_reg <= 1'b1;
            s2_emit_reg  <= s1_emit;
        end
        else if (s2_drain)
        begin
            s2_valid_reg <= 1'b0;
            s2_emit_reg  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_row_reg <= ctr_row;
            s2_col_reg <= ctr_col;
        end
    end

    // ---------------- stage 3: column reduce into output register ----------------
    logic [PW-1:0]  win_val;
    gdew_pkg::res_t res_reg;

    always_comb
    begin
        win_val = (mode_reg == gdew_pkg::MODE_ERODE) ? gdew_pkg::PIX_MAX : '0;
        for (int j = 0; j < MAX_KERNEL; j++)
        begin
            win_val = gdew_pkg::pick(mode_reg, win_val, row_res[j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s2_drain && s2_emit_reg)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_drain && s2_emit_reg)
        begin
            res_reg.value   <= win_val;
            res_reg.out_row <= s2_row_reg;
            res_reg.out_col <= s2_col_reg;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // ---------------- assertions ----------------
    // a new pixel never overwrites a stage-1 pixel that is not moving on
    a_s1_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        pix_acc && s1_valid_reg |-> s1_adv)
        else $error("stage 1 overwritten");

    // a blocked stage-2 item keeps its position
    a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s2_drain |=> s2_valid_reg && $stable(s2_row_reg)
                                      && $stable(s2_col_reg))
        else $error("stage 2 item lost");

    // a new result only comes from an emitting stage-2 item
    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(s2_valid_reg && s2_emit_reg))
        else $error("result without source");

    // forwarding tag tracks the most recent store write
    a_lw_track: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> lw_valid_reg && (lw_col_reg == $past(s1_col_reg)))
        else $error("forward tag stale");

endmodule

// ===== rtl/gdew_ram.sv =====
// gdew_ram: generic simple dual-port RAM, one write and one registered read port.
// Read returns the old contents on a same-address write. No dependencies.
module gdew_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/gdew_cell.sv =====
// gdew_cell: one row of the window. Holds the line store for its row (not in the
// last cell), the row's window registers and partial reduction. Uses gdew_pkg, gdew_ram.
module gdew_cell #(
    parameter int IMAGE_WIDTH = 512,
    parameter int MAX_KERNEL  = 7,
    parameter int IDX         = 0
) (
    input  logic                           clk,
    input  gdew_pkg::cell_ctrl_t           ctrl,
    input  logic [$clog2(IMAGE_WIDTH)-1:0] wr_addr,
    input  logic [$clog2(IMAGE_WIDTH)-1:0] rd_addr,
    input  logic [gdew_pkg::PIX_W-1:0]     col_in,   // this row's pixel of the new column
    output logic [gdew_pkg::PIX_W-1:0]     col_out,  // same column, one row older
    output logic [gdew_pkg::PIX_W-1:0]     row_res   // registered row max/min
);

    localparam int COL_W = $clog2(IMAGE_WIDTH);

    logic [gdew_pkg::PIX_W-1:0] win_reg  [MAX_KERNEL];
    logic [gdew_pkg::PIX_W-1:0] win_next [MAX_KERNEL];
    logic [gdew_pkg::PIX_W-1:0] row_next;
    logic [gdew_pkg::PIX_W-1:0] row_reg;

    generate
        if (IDX < MAX_KERNEL - 1)
        begin : g_store
            logic [gdew_pkg::PIX_W-1:0] rd_data;
            logic [gdew_pkg::PIX_W-1:0] last_reg;   // last value written to this row

            gdew_ram #(
                .WIDTH (gdew_pkg::PIX_W),
                .DEPTH (IMAGE_WIDTH)
            ) u_line (
                .clk     (clk),
                .wr_en   (ctrl.adv),
                .wr_addr (wr_addr[COL_W-1:0]),
                .wr_data (col_in),
                .rd_en   (ctrl.rd_en),
                .rd_addr (rd_addr[COL_W-1:0]),
                .rd_data (rd_data)
            );

            always_ff @(posedge clk)
            begin
                if (ctrl.adv)
                begin
                    last_reg <= col_in;
                end
            end

            assign col_out = ctrl.bypass ? last_reg : rd_data;
        end
        else
        begin : g_no_store
            assign col_out = '0;
        end
    endgenerate

    // window row shifts right, newest column at index 0
    always_comb
    begin
        win_next[0] = col_in;
        for (int i = 1; i < MAX_KERNEL; i++)
        begin
            win_next[i] = win_reg[i-1];
        end
    end

    // rows and columns outside the kernel contribute the identity value
    always_comb
    begin
        row_next = (ctrl.mode == gdew_pkg::MODE_ERODE) ? gdew_pkg::PIX_MAX : '0;
        for (int i = 0; i < MAX_KERNEL; i++)
        begin
            if (IDX < int'(ctrl.ksize) && i < int'(ctrl.ksize))
            begin
                row_next = gdew_pkg::pick(ctrl.mode, row_next, win_next[i]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv)
        begin
            win_reg <= win_next;
            row_reg <= row_next;
        end
    end

    assign row_res = row_reg;

endmodule

// ===== tb/sv/gdew_window_check.sv =====
// gdew_window_check: watches the pixel, result and config channels of the
// dilate/erode window block, predicts every window result and compares it.
// Depends on gdew_pkg for the request types and register codes.
module gdew_window_check #(
    parameter int IMAGE_WIDTH  = 512,
    parameter int IMAGE_HEIGHT = 512,
    parameter int MAX_KERNEL   = 7
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pix_valid,
    input  logic                               pix_ready,
    input  gdew_pkg::pix_t                     pix,
    input  logic                               res_valid,
    input  logic                               res_ready,
    input  gdew_pkg::res_t                     res,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [gdew_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gdew_pkg::KSZ_W-1:0]         cfg_data,
    output int                                 pending,
    output int                                 errors
);

    // per column, the pixels of the previous rows; entry 0 is the row just above
    logic [gdew_pkg::PIX_W-1:0] row_hist [MAX_KERNEL-1][IMAGE_WIDTH];
    // window columns, [row][col], column 0 newest, row 0 current row
    logic [gdew_pkg::PIX_W-1:0] win [MAX_KERNEL][MAX_KERNEL];
    int                         row_cnt;
    int                         col_cnt;
    logic                       mode_q;
    logic [gdew_pkg::KSZ_W-1:0] ksize_q;
    gdew_pkg::res_t             window_results [$];

    function automatic void slide_window(input logic [gdew_pkg::PIX_W-1:0] p,
                                         input logic fs);
        logic [gdew_pkg::PIX_W-1:0] column [MAX_KERNEL];
        logic [gdew_pkg::PIX_W-1:0] acc;
        int                         k;
        gdew_pkg::res_t             r;
        if (fs)
        begin
            row_cnt = 0;
            col_cnt = 0;
        end
        column[0] = p;
        for (int j = 1; j < MAX_KERNEL; j++)
            column[j] = row_hist[j-1][col_cnt];
        for (int j = MAX_KERNEL - 1; j > 1; j--)
            row_hist[j-1][col_cnt] = row_hist[j-2][col_cnt];
        row_hist[0][col_cnt] = p;
        for (int j = 0; j < MAX_KERNEL; j++)
        begin
            for (int i = MAX_KERNEL - 1; i > 0; i--)
                win[j][i] = win[j][i-1];
            win[j][0] = column[j];
        end

        k = (ksize_q == 0) ? 1 : ((ksize_q > MAX_KERNEL) ? MAX_KERNEL : int'(ksize_q));
        if (row_cnt + 1 >= k && col_cnt + 1 >= k)
        begin
            acc = (mode_q == gdew_pkg::MODE_ERODE) ? gdew_pkg::PIX_MAX : '0;
            for (int j = 0; j < k; j++)
                for (int i = 0; i < k; i++)
                    if (mode_q == gdew_pkg::MODE_ERODE ? (win[j][i] < acc)
                                                       : (win[j][i] > acc))
                        acc = win[j][i];
            r.value   = acc;
            // centre = top-left + k/2, lower-right middle for even k
            r.out_row = gdew_pkg::POS_W'(row_cnt + 1 - k + k / 2);
            r.out_col = gdew_pkg::POS_W'(col_cnt + 1 - k + k / 2);
            window_results.push_back(r);
        end

        col_cnt++;
        if (col_cnt >= IMAGE_WIDTH)
        begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= IMAGE_HEIGHT)
                row_cnt = 0;
        end
    endfunction

    function automatic void compare_field(input string name,
                                          input logic [gdew_pkg::PIX_W-1:0] want,
                                          input logic [gdew_pkg::PIX_W-1:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        gdew_pkg::res_t want;
        if (!rst_n)
        begin
            row_cnt = 0;
            col_cnt = 0;
            mode_q  = gdew_pkg::MODE_DILATE;
            ksize_q = gdew_pkg::KSZ_RESET;
            errors  = 0;
            window_results.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    gdew_pkg::CFG_MODE:   mode_q  = cfg_data[0];
                    gdew_pkg::CFG_KERNEL: ksize_q = cfg_data;
                    default:    ;
                endcase
            end
            if (res_valid && res_ready)
            begin
                if (window_results.size() == 0)
                begin
                    errors++;
                    $display({"%0t: unexpected result, expected none, ",
                              "got value %0d row %0d col %0d"},
                             $time, res.value, res.out_row, res.out_col);
                end
                else
                begin
                    want = window_results.pop_front();
                    compare_field("value", want.value, res.value);
                    compare_field("out_row", gdew_pkg::PIX_W'(want.out_row),
                                  gdew_pkg::PIX_W'(res.out_row));
                    compare_field("out_col", gdew_pkg::PIX_W'(want.out_col),
                                  gdew_pkg::PIX_W'(res.out_col));
                end
            end
            if (pix_valid && pix_ready)
                slide_window(pix.pixel, pix.frame_start);
        end
        pending = window_results.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
// testbench: drives pixel and config requests into the dilate/erode window
// block, paces the result side, and reports the verdict from gdew_window_check.
// Depends on gdew_pkg, grayscale_dilate_erode_window_top and gdew_window_check.
module testbench;

    localparam int IMG_W        = 512;
    localparam int IMG_H        = 512;
    localparam int MAX_K        = 7;
    localparam int CLK_PERIOD   = 4;
    // a correct run ends well inside this limit (about 1250 pixels under the
    // heaviest idling, plus the long hold-off)
    localparam int LIMIT_CYCLES = 100000;
    localparam int DRAIN_PAUSE  = 6;      // lets border pixels leave stage 1 and stage 2
    localparam int LONG_HOLD    = 400;    // receiver hold-off to back up the pipe
    localparam int SEGMENTS     = 12;
    localparam int SEG_LEN      = 102;    // 12 segments reach into row 2
    localparam int PRESSURE_SEG = 3;      // kernel 1: every pixel makes a result

    // register indexes the block does not decode; writes must be ignored
    localparam logic [gdew_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [gdew_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       pix_valid;
    logic                       pix_ready;
    gdew_pkg::pix_t             pix;
    logic                       res_valid;
    logic                       res_ready;
    gdew_pkg::res_t             res;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [gdew_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [gdew_pkg::KSZ_W-1:0] cfg_data;

    int               pending;
    int               errors;
    int               send_gap_pct;
    int               stall_pct;
    int               hold_asks;

    // pixel extremes and alternating bit patterns for the directed part
    logic [gdew_pkg::PIX_W-1:0] corner_vals [6] = '{15'h7FFF, 15'h0000, 15'h2AAA,
                                                    15'h5555, 15'h0001, 15'h4000};
    // kernel per segment; rows 0, 1 and 2 of the frame fall in segments
    // 0-5, 5-10 and 10-11, so only kernels up to 3 reach full windows
    int               kernel_plan [SEGMENTS] = '{1, 7, 0, 1, 5, 2, 2, 6, 1, 2, 3, 3};

    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    grayscale_dilate_erode_window_top #(
        .IMAGE_WIDTH  (IMG_W),
        .IMAGE_HEIGHT (IMG_H),
        .MAX_KERNEL   (MAX_K)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gdew_window_check #(
        .IMAGE_WIDTH  (IMG_W),
        .IMAGE_HEIGHT (IMG_H),
        .MAX_KERNEL   (MAX_K)
    ) u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix       (pix),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .errors    (errors)
    );

    // Mostly full-range random content, with the two extremes weighted up so
    // that ties and saturated windows show up often.
    function automatic logic [gdew_pkg::PIX_W-1:0] rand_pixel();
        case ($urandom_range(7, 0))
            0:       return '0;
            1:       return gdew_pkg::PIX_MAX;
            default: return gdew_pkg::PIX_W'($urandom_range(32767, 0));
        endcase
    endfunction

    // One pixel request. Called and returns at a falling edge; valid stays
    // high across back-to-back requests and only drops for a sender gap.
    task automatic send_pixel(input logic [gdew_pkg::PIX_W-1:0] p, input logic fs);
        gdew_pkg::pix_t req;
        req.pixel       = p;
        req.frame_start = fs;
        while ($urandom_range(99, 0) < send_gap_pct)
        begin
            pix_valid <= 1'b0;
            @(negedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= req;
        @(posedge clk);
        while (!pix_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Config write request. Only issued while the pipeline is empty.
    task automatic write_reg(input logic [gdew_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gdew_pkg::KSZ_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Stop offering pixels, let every predicted result come out, then give
    // border pixels (which make no result) time to leave the pipe.
    task automatic drain_pipe();
        pix_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_PAUSE) @(negedge clk);
    endtask

    // Result side: random stalls per the current phase, plus a long hold-off
    // whenever the stimulus asks for one.
    initial
    begin
        int holds_done;
        holds_done = 0;
        res_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_asks != holds_done)
            begin
                res_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                holds_done++;
            end
            res_ready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic [gdew_pkg::KSZ_W-1:0] kreg;
        logic                       mode_sel;

        rst_n        = 1'b0;
        pix_valid    = 1'b0;
        pix          = '0;
        cfg_valid    = 1'b0;
        cfg_index    = gdew_pkg::CFG_MODE;
        cfg_data     = '0;
        send_gap_pct = 0;
        stall_pct    = 0;
        hold_asks    = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset config is dilation 3x3, so row 0 yields nothing.
        send_pixel(gdew_pkg::PIX_MAX, 1'b1);
        send_pixel('0, 1'b0);
        send_pixel(15'h5555, 1'b0);
        drain_pipe();

        // Erosion, kernel zero (acts as 1): each pixel is its own window.
        // The spare-index writes carry values that would break this setup
        // if the block decoded them.
        write_reg(gdew_pkg::CFG_MODE, gdew_pkg::KSZ_W'(gdew_pkg::MODE_ERODE));
        write_reg(gdew_pkg::CFG_KERNEL, '0);
        write_reg(CFG_SPARE_A, '1);
        write_reg(CFG_SPARE_B, '0);
        for (int i = 0; i < 6; i++)
            send_pixel(corner_vals[i], i == 0);
        drain_pipe();

        // Dilation 1x1, continuing mid-row, then a frame restart mid-row.
        write_reg(gdew_pkg::CFG_MODE, gdew_pkg::KSZ_W'(gdew_pkg::MODE_DILATE));
        write_reg(gdew_pkg::CFG_KERNEL, 3'd1);
        for (int i = 0; i < 6; i++)
            send_pixel(corner_vals[5 - i], 1'b0);
        for (int i = 0; i < 3; i++)
            send_pixel(corner_vals[i], i == 0);
        drain_pipe();

        // Random segments of one frame: the first starts the frame, the rest
        // keep counting under a new config, so rows 1 and 2 are reached.
        for (int s = 0; s < SEGMENTS; s++)
        begin
            kreg = gdew_pkg::KSZ_W'(kernel_plan[s]);
            if (s < 10)
                mode_sel = (s % 2 == 1) ? gdew_pkg::MODE_ERODE : gdew_pkg::MODE_DILATE;
            else
                mode_sel = 1'($urandom_range(1, 0));
            write_reg(gdew_pkg::CFG_MODE, gdew_pkg::KSZ_W'(mode_sel));
            write_reg(gdew_pkg::CFG_KERNEL, kreg);

            case (s % 4)
                0:       begin send_gap_pct = 0;  stall_pct = 0;  end
                1:       begin send_gap_pct = 74; stall_pct = 0;  end
                2:       begin send_gap_pct = 0;  stall_pct = 74; end
                default: begin send_gap_pct = 26; stall_pct = 26; end
            endcase

            // back the pipe up: the receiver holds off while pixels keep coming
            if (s == PRESSURE_SEG)
                hold_asks++;
            for (int n = 0; n < SEG_LEN; n++)
                send_pixel(rand_pixel(), s == 0 && n == 0);
            drain_pipe();
        end

        if (errors == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("%0t: timeout, %0d results still outstanding", $time, pending);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
